FILE: rtl/lcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW decompressor package
// Shared item types, operation codes, command kinds and the job kinds passed
// from the front end to the expansion engine.
// ----------------------------------------------------------------------------
package lcw_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PUSH  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DECODING = 2'd0,
		ST_END      = 2'd1,
		ST_ERROR    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_CMD, PH_CNT_LO, PH_CNT_HI, PH_ARG_LO, PH_ARG_HI, PH_LIT, PH_REL_LO
	} phase_t;

	typedef enum logic [2:0] {
		K_FILL, K_LONG_COPY, K_REL_COPY, K_LITERAL, K_SHORT_COPY
	} kind_t;

	typedef enum logic [2:0] {
		JOB_START, JOB_READ, JOB_NOP, JOB_PUT, JOB_FILL, JOB_COPY, JOB_REL, JOB_END
	} job_t;

	typedef enum logic [1:0] {
		BE_IDLE, BE_RUN, BE_RDWAIT, BE_DONE
	} be_state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  in_byte;
		logic [15:0] read_addr;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [16:0] out_length;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		job_t        job;
		logic [7:0]  value;
		logic [15:0] count;
		logic [15:0] addr;
	} job_item_t;

endpackage

FILE: rtl/lcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW command parser
// Accepts items, tracks the command header bytes and emits one job per item.
// ----------------------------------------------------------------------------
module lcw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  lcw_pkg::in_item_t  data,
	output logic               job_valid,
	input  logic               job_stall,
	output lcw_pkg::job_item_t job
);

	lcw_pkg::phase_t phase_q;
	lcw_pkg::kind_t  kind_q;
	logic [15:0]     count_q;
	logic [15:0]     src_q;
	logic            done_q;
	logic            fire;
	logic [7:0]      b;

	assign stall = job_stall;
	assign job_valid = valid;
	assign fire = valid && !job_stall;
	assign b = data.in_byte;

	always_comb begin
		job.value = b;
		job.count = count_q;
		job.addr = data.read_addr;
		job.job = lcw_pkg::JOB_NOP;
		unique case (lcw_pkg::op_t'(data.operation))
			lcw_pkg::OP_START: job.job = lcw_pkg::JOB_START;
			lcw_pkg::OP_READ:  job.job = lcw_pkg::JOB_READ;
			lcw_pkg::OP_NONE:  job.job = lcw_pkg::JOB_NOP;
			lcw_pkg::OP_PUSH: begin
				if (!done_q) begin
					unique case (phase_q)
						lcw_pkg::PH_CMD: begin
							if (b[7:6] == 2'b10 && b[5:0] == 6'd0) begin
								job.job = lcw_pkg::JOB_END;
							end
						end
						lcw_pkg::PH_ARG_LO: begin
							if (kind_q == lcw_pkg::K_FILL) begin
								job.job = lcw_pkg::JOB_FILL;
							end
						end
						lcw_pkg::PH_ARG_HI: begin
							job.job = lcw_pkg::JOB_COPY;
							job.addr = {b, src_q[7:0]};
						end
						lcw_pkg::PH_LIT: job.job = lcw_pkg::JOB_PUT;
						lcw_pkg::PH_REL_LO: begin
							job.job = lcw_pkg::JOB_REL;
							job.addr = {4'd0, src_q[3:0], b};
						end
						default: job.job = lcw_pkg::JOB_NOP;
					endcase
				end
			end
			default: job.job = lcw_pkg::JOB_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcw_pkg::PH_CMD;
			kind_q  <= lcw_pkg::K_FILL;
			count_q <= '0;
			src_q   <= '0;
			done_q  <= 1'b0;
		end else if (fire) begin
			if (data.operation == lcw_pkg::OP_START) begin
				phase_q <= lcw_pkg::PH_CMD;
				kind_q  <= lcw_pkg::K_FILL;
				count_q <= '0;
				src_q   <= '0;
				done_q  <= 1'b0;
			end else if (data.operation == lcw_pkg::OP_PUSH && !done_q) begin
				unique case (phase_q)
					lcw_pkg::PH_CMD: begin
						if (b == 8'hFE || b == 8'hFF) begin
							kind_q  <= (b == 8'hFE) ? lcw_pkg::K_FILL : lcw_pkg::K_LONG_COPY;
							count_q <= '0;
							phase_q <= lcw_pkg::PH_CNT_LO;
						end else if (!b[7]) begin
							kind_q  <= lcw_pkg::K_REL_COPY;
							count_q <= 16'({1'b0, b[6:4]} + 4'd3);
							src_q   <= {8'd0, 4'd0, b[3:0]};
							phase_q <= lcw_pkg::PH_REL_LO;
						end else if (b[6] == 1'b0) begin
							count_q <= {10'd0, b[5:0]};
							if (b[5:0] == 6'd0) begin
								done_q <= 1'b1;
							end else begin
								kind_q  <= lcw_pkg::K_LITERAL;
								phase_q <= lcw_pkg::PH_LIT;
							end
						end else begin
							kind_q  <= lcw_pkg::K_SHORT_COPY;
							count_q <= 16'({1'b0, b[5:0]} + 7'd3);
							src_q   <= '0;
							phase_q <= lcw_pkg::PH_ARG_LO;
						end
					end
					lcw_pkg::PH_CNT_LO: begin
						count_q <= {8'd0, b};
						phase_q <= lcw_pkg::PH_CNT_HI;
					end
					lcw_pkg::PH_CNT_HI: begin
						count_q <= {b, count_q[7:0]};
						phase_q <= lcw_pkg::PH_ARG_LO;
					end
					lcw_pkg::PH_ARG_LO: begin
						if (kind_q == lcw_pkg::K_FILL) begin
							phase_q <= lcw_pkg::PH_CMD;
						end else begin
							src_q   <= {8'd0, b};
							phase_q <= lcw_pkg::PH_ARG_HI;
						end
					end
					lcw_pkg::PH_ARG_HI: phase_q <= lcw_pkg::PH_CMD;
					lcw_pkg::PH_LIT: begin
						count_q <= count_q - 16'd1;
						if (count_q <= 16'd1) begin
							phase_q <= lcw_pkg::PH_CMD;
						end
					end
					lcw_pkg::PH_REL_LO: phase_q <= lcw_pkg::PH_CMD;
					default: phase_q <= lcw_pkg::PH_CMD;
				endcase
			end
		end
	end

endmodule

FILE: rtl/lcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW job queue
// Two-entry queue between the parser and the expansion engine.
// ----------------------------------------------------------------------------
module lcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lcw_pkg::job_item_t in_job,
	output logic               out_valid,
	input  logic               out_take,
	output lcw_pkg::job_item_t out_job
);

	lcw_pkg::job_item_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	logic               push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign out_valid = (cnt_q != 2'd0);
	assign out_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (out_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, out_take});
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_take |-> out_valid)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !out_take) |=> cnt_q == 2'd2)
		else $error("queue lost an entry");

endmodule

FILE: rtl/lcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW expansion engine
// Owns the output memory and write pointer; runs fills one byte per cycle and
// copies through the registered read port, and produces one result item per job.
// ----------------------------------------------------------------------------
module lcw_back #(
	parameter int OUT_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_take,
	input  lcw_pkg::job_item_t job,
	output logic               valid,
	input  logic               stall,
	output lcw_pkg::out_item_t data
);

	localparam int AW = $clog2(OUT_DEPTH);

	lcw_pkg::be_state_t state_q, state_d;
	logic [7:0]       mem_q [OUT_DEPTH];
	logic [16:0]      wp_q;
	lcw_pkg::status_t status_q;
	logic [15:0]      left_q;
	logic [16:0]      src_q;
	logic             fill_q;
	logic [7:0]       fill_val_q;
	logic [7:0]       rd_q;
	logic [7:0]       res_rd_q;
	logic             out_valid_q;
	logic             rd_pend_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic             re_en;
	logic [AW-1:0]    re_addr;
	logic             full;
	logic             src_bad;
	logic             start_job;
	logic             finish;
	logic [16:0]      rel_src;

	assign full = (wp_q >= 17'(OUT_DEPTH));
	assign src_bad = (src_q >= wp_q) || (src_q >= 17'(OUT_DEPTH));
	assign start_job = (state_q == lcw_pkg::BE_IDLE) && job_valid && !out_valid_q;
	assign job_take = start_job;
	assign rel_src = wp_q - {1'b0, job.addr};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcw_pkg::BE_IDLE: begin
				if (start_job) begin
					if (job.job == lcw_pkg::JOB_READ) begin
						state_d = lcw_pkg::BE_RDWAIT;
					end else if ((job.job == lcw_pkg::JOB_FILL || job.job == lcw_pkg::JOB_COPY
						|| job.job == lcw_pkg::JOB_REL) && status_q == lcw_pkg::ST_DECODING) begin
						state_d = lcw_pkg::BE_RUN;
					end else begin
						state_d = lcw_pkg::BE_DONE;
					end
				end
			end
			lcw_pkg::BE_RUN: begin
				if (finish) begin
					state_d = lcw_pkg::BE_DONE;
				end
			end
			lcw_pkg::BE_RDWAIT: state_d = lcw_pkg::BE_DONE;
			lcw_pkg::BE_DONE: state_d = lcw_pkg::BE_IDLE;
			default: state_d = lcw_pkg::BE_IDLE;
		endcase
	end

	always_comb begin
		finish = 1'b0;
		wr_en = 1'b0;
		wr_addr = wp_q[AW-1:0];
		wr_data = rd_q;
		re_en = 1'b0;
		re_addr = src_q[AW-1:0];
		if (state_q == lcw_pkg::BE_RUN) begin
			if (left_q == 16'd0 || status_q != lcw_pkg::ST_DECODING) begin
				finish = 1'b1;
			end else if (fill_q) begin
				wr_en = !full;
				wr_data = fill_val_q;
				finish = full || left_q == 16'd1;
			end else if (!rd_pend_q) begin
				re_en = !src_bad;
			end else begin
				wr_en = !full;
				finish = full || left_q == 16'd1;
			end
		end else if (start_job && job.job == lcw_pkg::JOB_READ) begin
			re_en = 1'b1;
			re_addr = job.addr[AW-1:0];
		end else if (start_job && job.job == lcw_pkg::JOB_PUT) begin
			wr_en = !full && status_q == lcw_pkg::ST_DECODING;
			wr_data = job.value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re_en) begin
			rd_q <= mem_q[re_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcw_pkg::BE_IDLE;
			wp_q        <= '0;
			status_q    <= lcw_pkg::ST_DECODING;
			left_q      <= '0;
			src_q       <= '0;
			fill_q      <= 1'b0;
			fill_val_q  <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			res_rd_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !stall) begin
				out_valid_q <= 1'b0;
			end
			if (start_job) begin
				res_rd_q   <= '0;
				left_q     <= job.count;
				fill_q     <= (job.job == lcw_pkg::JOB_FILL);
				fill_val_q <= job.value;
				rd_pend_q  <= 1'b0;
				src_q      <= (job.job == lcw_pkg::JOB_REL) ? rel_src : {1'b0, job.addr};
				unique case (job.job)
					lcw_pkg::JOB_START: begin
						wp_q     <= '0;
						status_q <= lcw_pkg::ST_DECODING;
					end
					lcw_pkg::JOB_END: begin
						if (status_q == lcw_pkg::ST_DECODING) begin
							status_q <= lcw_pkg::ST_END;
						end
					end
					lcw_pkg::JOB_PUT: begin
						if (status_q == lcw_pkg::ST_DECODING) begin
							if (full) begin
								status_q <= lcw_pkg::ST_ERROR;
							end else begin
								wp_q <= wp_q + 17'd1;
							end
						end
					end
					lcw_pkg::JOB_REL: begin
						if (status_q == lcw_pkg::ST_DECODING && {1'b0, job.addr} > wp_q) begin
							status_q <= lcw_pkg::ST_ERROR;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == lcw_pkg::BE_RUN && left_q != 16'd0
				&& status_q == lcw_pkg::ST_DECODING) begin
				if (fill_q || rd_pend_q) begin
					if (full) begin
						status_q <= lcw_pkg::ST_ERROR;
					end else begin
						wp_q   <= wp_q + 17'd1;
						left_q <= left_q - 16'd1;
					end
					rd_pend_q <= 1'b0;
					src_q     <= src_q + 17'd1;
				end else if (src_bad) begin
					status_q <= lcw_pkg::ST_ERROR;
				end else begin
					rd_pend_q <= 1'b1;
				end
			end
			if (state_q == lcw_pkg::BE_RDWAIT) begin
				res_rd_q <= ({1'b0, src_q} < 18'(OUT_DEPTH)) ? rd_q : 8'd0;
			end
			if (state_q == lcw_pkg::BE_DONE) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	assign valid = out_valid_q;
	assign data.read_data = res_rd_q;
	assign data.out_length = wp_q;
	assign data.status = status_q;

	assert property (@(posedge clk) disable iff (!arst_n) wp_q <= 17'(OUT_DEPTH))
		else $error("write pointer past memory");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (status_q == lcw_pkg::ST_DECODING))
		else $error("write after end or error");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcw_pkg::BE_DONE) |-> !out_valid_q)
		else $error("result overwritten");

endmodule

FILE: rtl/lcw_format80_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW Format80 decompressor
// Expands LCW compressed bytes into an internal output memory.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/stall/in_data): start a frame, push one
// compressed byte, or read one output byte. Every item gives exactly one
// result item on the out channel (out_valid/out_stall/out_data) carrying the
// read byte, the current output length and the decode status.
// The parser classifies each byte in the cycle it is accepted and hands a job
// to a two-entry queue. The engine takes a job only while idle and with no
// result pending, passes through its done state and then offers the
// registered result; a read also waits in a state for the registered memory
// read port, a fill writes its bytes in the run state, and a copy reads each
// byte through the registered read port before it writes it.
// Reset clears the parser, write pointer and status; memory contents are
// undefined until written. While out_stall is high the finished result
// holds, the engine waits, and the queue fills and then stalls the input.
// ----------------------------------------------------------------------------
module lcw_format80_decompressor #(
	parameter int OUT_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lcw_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output lcw_pkg::out_item_t out_data
);

	logic               fj_valid;
	logic               fj_stall;
	lcw_pkg::job_item_t fj;
	logic               bj_valid;
	logic               bj_take;
	lcw_pkg::job_item_t bj;

	lcw_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall), .data(in_data),
		.job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
	);

	lcw_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(fj_valid), .in_stall(fj_stall), .in_job(fj),
		.out_valid(bj_valid), .out_take(bj_take), .out_job(bj)
	);

	lcw_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(bj_valid), .job_take(bj_take), .job(bj),
		.valid(out_valid), .stall(out_stall), .data(out_data)
	);

endmodule

FILE: bench/tb_lcw_format80_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCW Format80 decompressor testbench
// Feeds start, push and read items through a queue-fed driver with random
// gaps, predicts every result with a behavioral decoder held in this bench,
// and checks each result item field by field in a clocked monitor.
// ----------------------------------------------------------------------------
module tb_lcw_format80_decompressor;
	import lcw_pkg::*;

	localparam int OUT_DEPTH = 65536;
	localparam logic [7:0] CMD_FILL = 8'hFE;
	localparam logic [7:0] CMD_LONG_COPY = 8'hFF;
	localparam logic [7:0] CMD_END = 8'h80;
	localparam logic [7:0] CMD_LITERAL = 8'h80;
	localparam logic [7:0] CMD_SHORT_COPY = 8'hC0;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	lcw_format80_decompressor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Decoder state mirrored on the bench side.
	logic [7:0] dec_mem [OUT_DEPTH];
	int unsigned dec_wp;
	int unsigned written_top;
	phase_t dec_phase;
	kind_t dec_kind;
	int unsigned dec_count;
	int unsigned dec_src;
	status_t dec_status;

	in_item_t pending_items[$];
	bit pending_drain[$];
	out_item_t expected_results[$];
	int unsigned total_items;
	int unsigned sent_count;
	int unsigned recv_count;
	int unsigned errors;
	int unsigned send_gap;
	int unsigned send_quiet;
	int unsigned recv_gap;
	int unsigned recv_quiet;
	int unsigned hold_cycles;
	bit hold_done;

	function automatic bit write_byte(logic [7:0] v);
		if (dec_wp >= OUT_DEPTH) begin
			dec_status = ST_ERROR;
			return 0;
		end
		dec_mem[dec_wp] = v;
		dec_wp++;
		if (dec_wp > written_top)
			written_top = dec_wp;
		return 1;
	endfunction

	function automatic void copy_run(int unsigned src, int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if (src >= dec_wp || src >= OUT_DEPTH) begin
				dec_status = ST_ERROR;
				return;
			end
			if (!write_byte(dec_mem[src]))
				return;
			src++;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		case (dec_phase)
			PH_CMD: begin
				if (b == CMD_FILL || b == CMD_LONG_COPY) begin
					dec_kind = (b == CMD_FILL) ? K_FILL : K_LONG_COPY;
					dec_count = 0;
					dec_phase = PH_CNT_LO;
				end else if (b[7] == 1'b0) begin
					dec_kind = K_REL_COPY;
					dec_count = b[6:4] + 3;
					dec_src = {b[3:0], 8'h00};
					dec_phase = PH_REL_LO;
				end else if (b[7:6] == 2'b10) begin
					dec_count = b[5:0];
					if (dec_count == 0) begin
						dec_status = ST_END;
						dec_phase = PH_CMD;
					end else begin
						dec_kind = K_LITERAL;
						dec_phase = PH_LIT;
					end
				end else begin
					dec_kind = K_SHORT_COPY;
					dec_count = b[5:0] + 3;
					dec_src = 0;
					dec_phase = PH_ARG_LO;
				end
			end
			PH_CNT_LO: begin
				dec_count = b;
				dec_phase = PH_CNT_HI;
			end
			PH_CNT_HI: begin
				dec_count = (dec_count | (b << 8)) & 16'hFFFF;
				dec_phase = PH_ARG_LO;
			end
			PH_ARG_LO: begin
				if (dec_kind == K_FILL) begin
					dec_phase = PH_CMD;
					for (int unsigned i = 0; i < dec_count; i++)
						if (!write_byte(b))
							break;
				end else begin
					dec_src = b;
					dec_phase = PH_ARG_HI;
				end
			end
			PH_ARG_HI: begin
				dec_src = (dec_src | (b << 8)) & 16'hFFFF;
				dec_phase = PH_CMD;
				copy_run(dec_src, dec_count);
			end
			PH_LIT: begin
				if (dec_count > 0)
					dec_count--;
				if (dec_count == 0)
					dec_phase = PH_CMD;
				void'(write_byte(b));
			end
			PH_REL_LO: begin
				dec_src = (dec_src | b) & 12'hFFF;
				dec_phase = PH_CMD;
				if (dec_src > dec_wp)
					dec_status = ST_ERROR;
				else
					copy_run(dec_wp - dec_src, dec_count);
			end
			default: dec_phase = PH_CMD;
		endcase
	endfunction

	function automatic out_item_t decode_item(in_item_t it);
		out_item_t r;
		r.read_data = '0;
		case (op_t'(it.operation))
			OP_START: begin
				dec_wp = 0;
				dec_phase = PH_CMD;
				dec_kind = K_FILL;
				dec_count = 0;
				dec_src = 0;
				dec_status = ST_DECODING;
			end
			OP_PUSH: if (dec_status == ST_DECODING) decode_byte(it.in_byte);
			OP_READ: if (it.read_addr < OUT_DEPTH) r.read_data = dec_mem[it.read_addr];
			default: ;
		endcase
		r.out_length = dec_wp[16:0];
		r.status = dec_status;
		return r;
	endfunction

	task automatic queue_item(op_t op, logic [7:0] b, logic [15:0] addr, bit drain = 0);
		in_item_t it;
		it.operation = op;
		it.in_byte = b;
		it.read_addr = addr;
		expected_results.push_back(decode_item(it));
		pending_items.push_back(it);
		pending_drain.push_back(drain);
		total_items++;
	endtask

	task automatic push_byte(logic [7:0] b);
		queue_item(OP_PUSH, b, 16'($urandom));
	endtask

	task automatic read_written(int n);
		for (int i = 0; i < n; i++)
			if (written_top > 0)
				queue_item(OP_READ, 8'($urandom), 16'($urandom_range(0, written_top - 1)));
	endtask

	task automatic random_command();
		int unsigned pick;
		int unsigned n;
		int unsigned d;
		int unsigned s;
		pick = $urandom_range(0, 4);
		if (dec_wp == 0 && pick != 3)
			pick = 0;
		case (pick)
			0: begin
				push_byte(CMD_FILL);
				push_byte(8'($urandom_range(0, 12)));
				push_byte(8'h00);
				push_byte(8'($urandom));
			end
			1: begin
				s = $urandom_range(0, dec_wp - 1);
				push_byte(CMD_LONG_COPY);
				push_byte(8'($urandom_range(0, 10)));
				push_byte(8'h00);
				push_byte(s[7:0]);
				push_byte(s[15:8]);
			end
			2: begin
				d = $urandom_range(1, (dec_wp < 4095) ? dec_wp : 4095);
				n = $urandom_range(0, 7);
				push_byte({1'b0, n[2:0], d[11:8]});
				push_byte(d[7:0]);
			end
			3: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
				push_byte(CMD_LITERAL | 8'(n));
				for (int unsigned i = 0; i < n; i++)
					push_byte(8'($urandom));
			end
			default: begin
				s = $urandom_range(0, dec_wp - 1);
				push_byte(CMD_SHORT_COPY | 8'($urandom_range(0, 8'h3D)));
				push_byte(s[7:0]);
				push_byte(s[15:8]);
			end
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_lcw_format80_decompressor failed");
		$finish;
	end

	initial begin
		int unsigned random_start;
		arst_n = 1'b0;
		dec_wp = 0;
		written_top = 0;
		dec_phase = PH_CMD;
		dec_kind = K_FILL;
		dec_count = 0;
		dec_src = 0;
		dec_status = ST_DECODING;
		total_items = 0;
		errors = 0;

		// Directed: each command kind, overlap, zero count, faults and end.
		queue_item(OP_START, 8'h00, 16'h0000);
		push_byte(8'h83); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h5A);
		push_byte(CMD_FILL); push_byte(8'h05); push_byte(8'h00); push_byte(8'hAA);
		push_byte(CMD_LONG_COPY); push_byte(8'h03); push_byte(8'h00);
		push_byte(8'h01); push_byte(8'h00);
		push_byte(8'h70); push_byte(8'h02);
		push_byte(8'hC1); push_byte(8'h00); push_byte(8'h00);
		push_byte(CMD_FILL); push_byte(8'h00); push_byte(8'h00); push_byte(8'h55);
		read_written(3);
		queue_item(OP_NONE, 8'hFF, 16'hFFFF);
		push_byte(CMD_LONG_COPY); push_byte(8'h02); push_byte(8'h00);
		push_byte(8'(dec_wp)); push_byte(8'(dec_wp >> 8));
		push_byte(8'h81);
		queue_item(OP_START, 8'hFF, 16'hFFFF);
		push_byte(8'h0F); push_byte(8'hFF);
		queue_item(OP_START, 8'h00, 16'h0000);
		push_byte(CMD_END);
		push_byte(8'h81);
		queue_item(OP_START, 8'h00, 16'h0000);
		push_byte(CMD_FILL); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h3C);
		push_byte(CMD_FILL); push_byte(8'h02); push_byte(8'h00); push_byte(8'hC3);
		queue_item(OP_READ, 8'h00, 16'hFFFF, 1);
		queue_item(OP_READ, 8'h00, 16'h0000);

		random_start = total_items;
		while (total_items - random_start < 400) begin
			queue_item(OP_START, 8'($urandom), 16'($urandom), $urandom_range(0, 5) == 0);
			if ($urandom_range(0, 6) == 0) begin
				for (int i = $urandom_range(1, 8); i > 0; i--)
					push_byte(8'($urandom));
			end else begin
				for (int i = $urandom_range(1, 6); i > 0; i--)
					random_command();
				if ($urandom_range(0, 3) != 0)
					push_byte(CMD_END);
			end
			read_written($urandom_range(1, 4));
			if ($urandom_range(0, 9) == 0)
				queue_item(OP_NONE, 8'($urandom), 16'($urandom));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent_count == total_items && recv_count == total_items);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_lcw_format80_decompressor passed");
		else
			$display("tb_lcw_format80_decompressor failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
			send_quiet <= 0;
			sent_count <= 0;
		end else begin : drive
			int unsigned sent_next;
			sent_next = sent_count + ((in_valid && !in_stall) ? 1 : 0);
			sent_count <= sent_next;
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 &&
						!(pending_drain[0] && sent_next != recv_count)) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					void'(pending_drain.pop_front());
					if (send_quiet > 0) begin
						send_quiet <= send_quiet - 1;
						send_gap <= 0;
					end else begin
						send_gap <= $urandom_range(0, 15);
						if ($urandom_range(0, 15) == 0)
							send_quiet <= $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			recv_count <= 0;
			recv_gap <= 0;
			recv_quiet <= 0;
			hold_cycles <= 0;
			hold_done <= 1'b0;
		end else begin : observe
			out_item_t want;
			logic taken;
			taken = out_valid && !out_stall;
			if (taken) begin
				recv_count <= recv_count + 1;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.read_data !== want.read_data) begin
						errors++;
						$display("%0t: read_data expected %h actual %h",
							$time, want.read_data, out_data.read_data);
					end
					if (out_data.out_length !== want.out_length) begin
						errors++;
						$display("%0t: out_length expected %h actual %h",
							$time, want.out_length, out_data.out_length);
					end
					if (out_data.status !== want.status) begin
						errors++;
						$display("%0t: status expected %h actual %h",
							$time, want.status, out_data.status);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && recv_count == 60) begin
				hold_done <= 1'b1;
				hold_cycles <= 300;
				out_stall <= 1'b1;
			end else if (taken) begin
				if (recv_quiet > 0) begin
					recv_quiet <= recv_quiet - 1;
					recv_gap <= 0;
					out_stall <= 1'b0;
				end else begin : draw
					int unsigned g;
					g = $urandom_range(0, 15);
					recv_gap <= g;
					out_stall <= (g != 0);
					if ($urandom_range(0, 15) == 0)
						recv_quiet <= $urandom_range(20, 60);
				end
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= (recv_gap > 1);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

endmodule
